@@ rtl/twi_seq_pkg.sv @@
// twi_seq_pkg: shared types and constants of the twi packet sequencer
// no dependencies; imported by twi_seq_ctrl, twi_seq_oreg, twi_seq_check, the top level and the testbench

package twi_seq_pkg;

	// item kinds on the input channel
	localparam logic [1:0] KIND_EVENT = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_SEND  = 2'd2;
	localparam logic [1:0] KIND_MREAD = 2'd3;

	// configuration register indexes
	localparam logic CFG_SLAVE_ENABLED  = 1'b0;
	localparam logic CFG_SLAVE_CAPACITY = 1'b1;

	localparam logic [7:0] STATUS_MASK  = 8'hF8;
	localparam logic [7:0] SLAVE_CAP_MAX = 8'd254;
	localparam logic [7:0] SLAVE_CAP_RESET = 8'd32;

	// masked twi status codes
	localparam logic [7:0] ST_START          = 8'h08;
	localparam logic [7:0] ST_REP_START      = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK     = 8'h18;
	localparam logic [7:0] ST_MT_SLA_NACK    = 8'h20;
	localparam logic [7:0] ST_MT_DATA_ACK    = 8'h28;
	localparam logic [7:0] ST_MT_DATA_NACK   = 8'h30;
	localparam logic [7:0] ST_ARB_LOST       = 8'h38;
	localparam logic [7:0] ST_MR_SLA_ACK     = 8'h40;
	localparam logic [7:0] ST_MR_SLA_NACK    = 8'h48;
	localparam logic [7:0] ST_MR_DATA_ACK    = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NACK   = 8'h58;
	localparam logic [7:0] ST_SR_SLA_ACK     = 8'h60;
	localparam logic [7:0] ST_SR_ARB_SLA_ACK = 8'h68;
	localparam logic [7:0] ST_SR_ARB_GCALL   = 8'h78;
	localparam logic [7:0] ST_SR_DATA_ACK    = 8'h80;
	localparam logic [7:0] ST_SR_DATA_NACK   = 8'h88;
	localparam logic [7:0] ST_SR_STOP        = 8'hA0;

	// control bit positions
	localparam int CTRL_INT   = 0;
	localparam int CTRL_ACK   = 1;
	localparam int CTRL_START = 2;
	localparam int CTRL_STOP  = 3;

	localparam logic CHAN_SLAVE  = 1'b0;
	localparam logic CHAN_MASTER = 1'b1;

	typedef struct packed {
		logic       ctrl_write;
		logic [3:0] ctrl_bits;
		logic       tx_valid;
		logic       tx_from_mem;
		logic [7:0] tx_byte;
		logic       channel;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [7:0] rx_index;
		logic       deliver_valid;
		logic [7:0] deliver_length;
		logic       send_done;
	} res_t;

endpackage

@@ rtl/twi_seq_store.sv @@
// twi_seq_store: transmit byte memory, one write and one registered read port
// no package dependencies

module twi_seq_store #(
	parameter int TX_DEPTH = 256,
	parameter int AW = $clog2(TX_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [TX_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data held until the next read so it stays aligned with its stage
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/twi_seq_ctrl.sv @@
// twi_seq_ctrl: sequencer state, configuration registers and per-item decision
// depends on twi_seq_pkg; drives the ports of twi_seq_store

module twi_seq_ctrl #(
	parameter int TX_DEPTH = 256,
	parameter int AW = $clog2(TX_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               acc,
	input  logic [1:0]         kind,
	input  logic [7:0]         status,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         index,
	input  logic [6:0]         address,
	input  logic [7:0]         length,
	output twi_seq_pkg::res_t  res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [7:0]         mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr
);

	import twi_seq_pkg::*;

	logic       slave_en_q;
	logic [7:0] slave_cap_q;

	logic       bus_held_q, nack_next_q, tx_pending_q, mr_pending_q;
	logic [6:0] tx_dest_q, mr_address_q;
	logic [7:0] tx_length_q, tx_position_q, slave_count_q;
	logic [7:0] mr_capacity_q, mr_count_q;

	logic       bus_held_d, nack_next_d, tx_pending_d, mr_pending_d;
	logic [6:0] tx_dest_d, mr_address_d;
	logic [7:0] tx_length_d, tx_position_d, slave_count_d;
	logic [7:0] mr_capacity_d, mr_count_d;

	logic       do_ctrl, int_clr, need, rd;
	logic [7:0] status_m, cap, mr_count_inc;
	res_t       r;

	assign status_m     = status & STATUS_MASK;
	assign cap          = (slave_cap_q > SLAVE_CAP_MAX) ? SLAVE_CAP_MAX : slave_cap_q;
	assign mr_count_inc = mr_count_q + 8'd1;

	always_comb begin
		bus_held_d    = bus_held_q;
		nack_next_d   = nack_next_q;
		tx_pending_d  = tx_pending_q;
		mr_pending_d  = mr_pending_q;
		tx_dest_d     = tx_dest_q;
		mr_address_d  = mr_address_q;
		tx_length_d   = tx_length_q;
		tx_position_d = tx_position_q;
		slave_count_d = slave_count_q;
		mr_capacity_d = mr_capacity_q;
		mr_count_d    = mr_count_q;
		r       = '0;
		do_ctrl = 1'b0;
		int_clr = 1'b0;
		rd      = 1'b0;
		need    = 1'b0;

		unique case (kind)
			KIND_LOAD: begin
				// store write is driven below
			end
			KIND_SEND: begin
				if (!tx_pending_q && !bus_held_q) begin
					tx_pending_d = 1'b1;
					tx_dest_d    = address;
					tx_length_d  = ({1'b0, length} > 9'(TX_DEPTH)) ? 8'(TX_DEPTH) : length;
					do_ctrl      = 1'b1;
				end
			end
			KIND_MREAD: begin
				if (!mr_pending_q) begin
					mr_pending_d  = 1'b1;
					mr_address_d  = address;
					mr_capacity_d = length;
					do_ctrl       = 1'b1;
				end
			end
			default: begin
				do_ctrl = 1'b1;
				int_clr = 1'b1;
				unique case (status_m)
					ST_START, ST_REP_START: begin
						if (tx_pending_q) begin
							r.tx_valid    = 1'b1;
							r.tx_byte     = {tx_dest_q, 1'b0};
							tx_position_d = '0;
							bus_held_d    = 1'b1;
						end else if (mr_pending_q) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = {mr_address_q, 1'b1};
							mr_count_d = '0;
							bus_held_d = 1'b1;
						end
					end
					ST_MT_SLA_NACK, ST_MT_DATA_NACK: begin
						if (tx_pending_q) begin
							tx_pending_d = 1'b0;
							r.send_done  = 1'b1;
						end
					end
					ST_ARB_LOST, ST_SR_ARB_GCALL: begin
						bus_held_d = 1'b0;
					end
					ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
						if (tx_pending_q) begin
							if (tx_position_q >= tx_length_q) begin
								tx_pending_d = 1'b0;
								r.send_done  = 1'b1;
							end else begin
								// byte comes from the store's registered read, merged in the result stage
								r.tx_valid    = 1'b1;
								r.tx_from_mem = 1'b1;
								rd            = 1'b1;
								tx_position_d = tx_position_q + 8'd1;
							end
						end
					end
					ST_SR_SLA_ACK, ST_SR_ARB_SLA_ACK: begin
						if (status_m == ST_SR_ARB_SLA_ACK) begin
							bus_held_d = 1'b0;
						end
						if (!slave_en_q || slave_count_q != 8'd0) begin
							nack_next_d = 1'b1;
						end
					end
					ST_SR_DATA_ACK: begin
						if (!slave_en_q) begin
							nack_next_d = 1'b1;
						end else if (slave_count_q >= cap) begin
							nack_next_d   = 1'b1;
							slave_count_d = cap + 8'd1;
						end else begin
							r.channel     = CHAN_SLAVE;
							r.rx_valid    = 1'b1;
							r.rx_byte     = data_byte;
							r.rx_index    = slave_count_q;
							slave_count_d = slave_count_q + 8'd1;
						end
					end
					ST_SR_DATA_NACK: begin
						if (slave_en_q) begin
							slave_count_d = cap + 8'd1;
						end
					end
					ST_SR_STOP: begin
						if (slave_en_q) begin
							if (slave_count_q != 8'd0 && slave_count_q <= cap) begin
								r.channel        = CHAN_SLAVE;
								r.deliver_valid  = 1'b1;
								r.deliver_length = slave_count_q;
							end
							slave_count_d = '0;
						end
					end
					ST_MR_SLA_ACK: begin
						if (mr_pending_q && mr_capacity_q != 8'd0 &&
						    mr_count_q == mr_capacity_q - 8'd1) begin
							nack_next_d = 1'b1;
						end
					end
					ST_MR_DATA_ACK, ST_MR_DATA_NACK: begin
						if (mr_pending_q) begin
							if (mr_count_q >= mr_capacity_q) begin
								// read marked invalid
								mr_count_d = (mr_capacity_q == 8'd255) ? 8'd255
								             : mr_capacity_q + 8'd1;
							end else begin
								r.channel  = CHAN_MASTER;
								r.rx_valid = 1'b1;
								r.rx_byte  = data_byte;
								r.rx_index = mr_count_q;
								mr_count_d = mr_count_inc;
								if (mr_capacity_q != 8'd0 &&
								    mr_count_inc == mr_capacity_q - 8'd1) begin
									nack_next_d = 1'b1;
								end
								if (mr_count_inc == mr_capacity_q) begin
									r.deliver_valid  = 1'b1;
									r.deliver_length = mr_count_inc;
									mr_pending_d     = 1'b0;
								end
							end
						end
					end
					ST_MR_SLA_NACK: begin
						if (mr_pending_q) begin
							r.channel        = CHAN_MASTER;
							r.deliver_valid  = 1'b1;
							r.deliver_length = mr_count_q;
							mr_pending_d     = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		endcase

		// control register write sees the state left by this item
		if (do_ctrl) begin
			need                   = tx_pending_d || mr_pending_d;
			r.ctrl_write           = 1'b1;
			r.ctrl_bits[CTRL_INT]  = int_clr;
			r.ctrl_bits[CTRL_ACK]  = !nack_next_d;
			nack_next_d            = 1'b0;
			r.ctrl_bits[CTRL_START] = need && !bus_held_d;
			if (!need && bus_held_d) begin
				r.ctrl_bits[CTRL_STOP] = 1'b1;
				bus_held_d             = 1'b0;
			end
		end
	end

	assign res       = r;
	assign mem_we    = acc && (kind == KIND_LOAD) && ({1'b0, index} < 9'(TX_DEPTH));
	assign mem_waddr = index[AW-1:0];
	assign mem_wdata = data_byte;
	assign mem_re    = acc && rd;
	assign mem_raddr = tx_position_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_en_q  <= 1'b0;
			slave_cap_q <= SLAVE_CAP_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SLAVE_ENABLED) begin
				slave_en_q <= cfg_data[0];
			end else begin
				slave_cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_held_q    <= 1'b0;
			nack_next_q   <= 1'b0;
			tx_pending_q  <= 1'b0;
			mr_pending_q  <= 1'b0;
			tx_dest_q     <= '0;
			mr_address_q  <= '0;
			tx_length_q   <= '0;
			tx_position_q <= '0;
			slave_count_q <= '0;
			mr_capacity_q <= '0;
			mr_count_q    <= '0;
		end else if (acc) begin
			bus_held_q    <= bus_held_d;
			nack_next_q   <= nack_next_d;
			tx_pending_q  <= tx_pending_d;
			mr_pending_q  <= mr_pending_d;
			tx_dest_q     <= tx_dest_d;
			mr_address_q  <= mr_address_d;
			tx_length_q   <= tx_length_d;
			tx_position_q <= tx_position_d;
			slave_count_q <= slave_count_d;
			mr_capacity_q <= mr_capacity_d;
			mr_count_q    <= mr_count_d;
		end
	end

endmodule

@@ rtl/twi_seq_oreg.sv @@
// twi_seq_oreg: result stage aligned with the store read, plus output register
// depends on twi_seq_pkg

module twi_seq_oreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  twi_seq_pkg::res_t res_c,
	input  logic [7:0]        mem_rdata,
	input  logic              out_ready,
	output logic              in_ready,
	output logic              out_valid,
	output twi_seq_pkg::res_t res_out
);

	import twi_seq_pkg::*;

	logic s1_valid_s1, out_valid_q, move;
	res_t res_s1, res_q, merged;

	assign move     = s1_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || move;

	always_comb begin
		merged = res_s1;
		if (res_s1.tx_from_mem) begin
			merged.tx_byte = mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_s1 <= 1'b1;
			end else if (move) begin
				s1_valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res_c;
		end
		if (move) begin
			res_q <= merged;
		end
	end

	assign out_valid = out_valid_q;
	assign res_out   = res_q;

endmodule

@@ rtl/twi_packet_sequencer.sv @@
// twi_packet_sequencer: top level of the packet-level i2c sequencer
// depends on twi_seq_pkg, twi_seq_ctrl, twi_seq_store, twi_seq_oreg
//
// Usage: every transfer on the input channel (in_valid/in_ready) is one item:
// a masked twi status event, a load of one transmit byte, a send request or a
// master read request. Each item gives exactly one result transfer on the
// output channel (out_valid/out_ready), in order. Configuration (slave enable,
// slave capacity) is written through cfg_we/cfg_index/cfg_data while idle.
// A result passes through the result stage and then the output register before it
// is offered on the output channel. The sequencer state updates in the accept
// cycle and the transmit memory is read then; its registered read data joins the
// result in the result stage.
// Throughput: one item per cycle when not stalled; the result stage and the
// output register let a new item enter while an earlier result waits at the
// output. On a receiver stall, in_ready drops once both stages hold a result.
// Reset clears all sequencer state and sets the configuration to slave
// disabled, capacity 32. The transmit memory is not cleared: bytes must be
// loaded before they are sent.

module twi_packet_sequencer #(
	parameter int TX_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] status,
	input  logic [7:0] data_byte,
	input  logic [7:0] index,
	input  logic [6:0] address,
	input  logic [7:0] length,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       ctrl_write,
	output logic [3:0] ctrl_bits,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       channel,
	output logic       rx_valid,
	output logic [7:0] rx_byte,
	output logic [7:0] rx_index,
	output logic       deliver_valid,
	output logic [7:0] deliver_length,
	output logic       send_done
);

	import twi_seq_pkg::*;

	localparam int AW = $clog2(TX_DEPTH);

	logic          acc, mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;
	res_t          res_c, res_out;

	assign acc = in_valid && in_ready;

	twi_seq_ctrl #(.TX_DEPTH(TX_DEPTH), .AW(AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.kind      (kind),
		.status    (status),
		.data_byte (data_byte),
		.index     (index),
		.address   (address),
		.length    (length),
		.res       (res_c),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	twi_seq_store #(.TX_DEPTH(TX_DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	twi_seq_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.res_c     (res_c),
		.mem_rdata (mem_rdata),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	assign ctrl_write     = res_out.ctrl_write;
	assign ctrl_bits      = res_out.ctrl_bits;
	assign tx_valid       = res_out.tx_valid;
	assign tx_byte        = res_out.tx_byte;
	assign channel        = res_out.channel;
	assign rx_valid       = res_out.rx_valid;
	assign rx_byte        = res_out.rx_byte;
	assign rx_index       = res_out.rx_index;
	assign deliver_valid  = res_out.deliver_valid;
	assign deliver_length = res_out.deliver_length;
	assign send_done      = res_out.send_done;

endmodule

@@ rtl/twi_seq_check.sv @@
// twi_seq_check: port-level assertions for twi_packet_sequencer
// depends on twi_seq_pkg; bound to the top level below

module twi_seq_check (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       ctrl_write,
	input logic [3:0] ctrl_bits,
	input logic       tx_valid,
	input logic       rx_valid,
	input logic       deliver_valid,
	input logic       send_done
);

	import twi_seq_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// start and stop are never requested together
	a_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ctrl_write |-> !(ctrl_bits[CTRL_START] && ctrl_bits[CTRL_STOP]))
		else $error("start and stop in one control write");

	// any activity comes with a control write
	a_activity_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tx_valid || rx_valid || deliver_valid || send_done) |-> ctrl_write)
		else $error("activity without control write");

	// a byte is either sent or received, never both in one result
	a_tx_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tx_valid && rx_valid))
		else $error("tx and rx in one result");

endmodule

bind twi_packet_sequencer twi_seq_check u_check (.*);

@@ sim/tb_twi_packet_sequencer.sv @@
// tb_twi_packet_sequencer: self-checking testbench for the twi packet sequencer
// a shadow class predicts every result from the accepted items; plain tasks drive
// directed and random i2c transactions; depends on twi_seq_pkg and the rtl
`timescale 1ns / 1ps

import twi_seq_pkg::*;

typedef struct packed {
	logic       ctrl_write;
	logic [3:0] ctrl_bits;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       channel;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic [7:0] rx_index;
	logic       deliver_valid;
	logic [7:0] deliver_length;
	logic       send_done;
} seq_reaction_t;

class twi_shadow;
	bit line_owned, refuse_next, out_busy, rd_busy;
	logic [6:0] out_peer, rd_peer;
	logic [7:0] out_len, out_pos, in_fill, rd_room, rd_got;
	logic [7:0] out_bytes [256];
	bit slave_on;
	logic [7:0] slave_room;
	seq_reaction_t awaited_reactions [$];
	int errors;

	function new();
		line_owned = 0; refuse_next = 0; out_busy = 0; rd_busy = 0;
		out_peer = '0; rd_peer = '0;
		out_len = '0; out_pos = '0; in_fill = '0; rd_room = '0; rd_got = '0;
		slave_on = 0;
		slave_room = SLAVE_CAP_RESET;
		errors = 0;
	endfunction

	function void configure(logic idx, logic [7:0] value);
		if (idx == CFG_SLAVE_ENABLED)
			slave_on = value[0];
		else
			slave_room = value;
	endfunction

	// control register write: ack unless a nack was scheduled, start/stop by pending work
	function logic [3:0] ctrl_word(bit int_clear);
		logic [3:0] bits;
		bit busy;
		bits = '0;
		bits[CTRL_INT] = int_clear;
		busy = out_busy || rd_busy;
		if (!refuse_next) bits[CTRL_ACK] = 1'b1;
		refuse_next = 0;
		if (busy && !line_owned) bits[CTRL_START] = 1'b1;
		if (!busy && line_owned) begin
			bits[CTRL_STOP] = 1'b1;
			line_owned = 0;
		end
		return bits;
	endfunction

	// nack the last byte of a master read
	function void arm_read_nack();
		if (rd_busy && rd_room != 0 && rd_got == rd_room - 8'd1)
			refuse_next = 1;
	endfunction

	function void note_item(logic [1:0] k, logic [7:0] st_raw, logic [7:0] db,
			logic [7:0] idx, logic [6:0] addr, logic [7:0] len);
		seq_reaction_t r;
		logic [7:0] st, room;
		r = '0;
		st = st_raw & STATUS_MASK;
		room = (slave_room > SLAVE_CAP_MAX) ? SLAVE_CAP_MAX : slave_room;
		case (k)
			KIND_LOAD: out_bytes[idx] = db;
			KIND_SEND: begin
				if (!out_busy && !line_owned) begin
					out_busy = 1;
					out_peer = addr;
					out_len = len;
					r.ctrl_write = 1'b1;
					r.ctrl_bits = ctrl_word(1'b0);
				end
			end
			KIND_MREAD: begin
				if (!rd_busy) begin
					rd_busy = 1;
					rd_peer = addr;
					rd_room = len;
					r.ctrl_write = 1'b1;
					r.ctrl_bits = ctrl_word(1'b0);
				end
			end
			default: begin
				case (st)
					ST_START, ST_REP_START: begin
						if (out_busy) begin
							r.tx_valid = 1'b1;
							r.tx_byte = {out_peer, 1'b0};
							out_pos = '0;
							line_owned = 1;
						end else if (rd_busy) begin
							r.tx_valid = 1'b1;
							r.tx_byte = {rd_peer, 1'b1};
							rd_got = '0;
							line_owned = 1;
						end
					end
					ST_MT_SLA_NACK, ST_MT_DATA_NACK: begin
						if (out_busy) begin
							out_busy = 0;
							r.send_done = 1'b1;
						end
					end
					ST_ARB_LOST, ST_SR_ARB_GCALL: line_owned = 0;
					ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
						if (out_busy) begin
							if (out_pos >= out_len) begin
								out_busy = 0;
								r.send_done = 1'b1;
							end else begin
								r.tx_valid = 1'b1;
								r.tx_byte = out_bytes[out_pos];
								out_pos = out_pos + 8'd1;
							end
						end
					end
					ST_SR_SLA_ACK, ST_SR_ARB_SLA_ACK: begin
						if (st == ST_SR_ARB_SLA_ACK) line_owned = 0;
						if (!slave_on || in_fill != 0) refuse_next = 1;
					end
					ST_SR_DATA_ACK: begin
						if (!slave_on) begin
							refuse_next = 1;
						end else if (in_fill >= room) begin
							// overflow poisons the packet until the stop
							refuse_next = 1;
							in_fill = room + 8'd1;
						end else begin
							r.channel = CHAN_SLAVE;
							r.rx_valid = 1'b1;
							r.rx_byte = db;
							r.rx_index = in_fill;
							in_fill = in_fill + 8'd1;
						end
					end
					ST_SR_DATA_NACK: if (slave_on) in_fill = room + 8'd1;
					ST_SR_STOP: begin
						if (slave_on) begin
							if (in_fill > 0 && in_fill <= room) begin
								r.channel = CHAN_SLAVE;
								r.deliver_valid = 1'b1;
								r.deliver_length = in_fill;
							end
							in_fill = '0;
						end
					end
					ST_MR_SLA_ACK: arm_read_nack();
					ST_MR_DATA_ACK, ST_MR_DATA_NACK: begin
						if (rd_busy) begin
							if (rd_got >= rd_room) begin
								rd_got = (rd_room == 8'hFF) ? 8'hFF : rd_room + 8'd1;
							end else begin
								r.channel = CHAN_MASTER;
								r.rx_valid = 1'b1;
								r.rx_byte = db;
								r.rx_index = rd_got;
								rd_got = rd_got + 8'd1;
								arm_read_nack();
								if (rd_got == rd_room) begin
									r.deliver_valid = 1'b1;
									r.deliver_length = rd_got;
									rd_busy = 0;
								end
							end
						end
					end
					ST_MR_SLA_NACK: begin
						if (rd_busy) begin
							r.channel = CHAN_MASTER;
							r.deliver_valid = 1'b1;
							r.deliver_length = rd_got;
							rd_busy = 0;
						end
					end
					default: ;
				endcase
				r.ctrl_write = 1'b1;
				r.ctrl_bits = ctrl_word(1'b1);
			end
		endcase
		awaited_reactions.push_back(r);
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(seq_reaction_t got);
		seq_reaction_t want;
		if (awaited_reactions.size() == 0) begin
			$error("result transfer with no item awaiting it");
			errors++;
			return;
		end
		want = awaited_reactions.pop_front();
		compare_field("ctrl_write", 8'(want.ctrl_write), 8'(got.ctrl_write));
		compare_field("ctrl_bits", 8'(want.ctrl_bits), 8'(got.ctrl_bits));
		compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
		compare_field("tx_byte", want.tx_byte, got.tx_byte);
		compare_field("channel", 8'(want.channel), 8'(got.channel));
		compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
		compare_field("rx_byte", want.rx_byte, got.rx_byte);
		compare_field("rx_index", want.rx_index, got.rx_index);
		compare_field("deliver_valid", 8'(want.deliver_valid), 8'(got.deliver_valid));
		compare_field("deliver_length", want.deliver_length, got.deliver_length);
		compare_field("send_done", 8'(want.send_done), 8'(got.send_done));
	endfunction
endclass

module tb_twi_packet_sequencer;

	localparam logic [7:0] ST_UNLISTED = 8'hF8;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] kind;
	logic [7:0] status;
	logic [7:0] data_byte;
	logic [7:0] index;
	logic [6:0] address;
	logic [7:0] length;
	logic       out_valid;
	logic       out_ready;
	logic       ctrl_write;
	logic [3:0] ctrl_bits;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       channel;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic [7:0] rx_index;
	logic       deliver_valid;
	logic [7:0] deliver_length;
	logic       send_done;

	twi_shadow shadow;
	bit        stocked [256];
	bit        sender_steady;
	bit        sink_steady;
	int        offered;

	twi_packet_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.status(status),
		.data_byte(data_byte),
		.index(index),
		.address(address),
		.length(length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctrl_write(ctrl_write),
		.ctrl_bits(ctrl_bits),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.channel(channel),
		.rx_valid(rx_valid),
		.rx_byte(rx_byte),
		.rx_index(rx_index),
		.deliver_valid(deliver_valid),
		.deliver_length(deliver_length),
		.send_done(send_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("twi_packet_sequencer: mismatch");
		$finish;
	end

	task automatic offer(input logic [1:0] k, input logic [7:0] st, input logic [7:0] db,
			input logic [7:0] idx, input logic [6:0] addr, input logic [7:0] len);
		int gap;
		if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
		gap = sender_steady ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= k;
		status <= st;
		data_byte <= db;
		index <= idx;
		address <= addr;
		length <= len;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		shadow.note_item(k, st, db, idx, addr, len);
		if (k == KIND_LOAD) stocked[idx] = 1'b1;
		offered++;
	endtask

	// status low bits are junk that the block must mask
	task automatic event_byte(input logic [7:0] code, input logic [7:0] db);
		offer(KIND_EVENT, code | 8'($urandom_range(0, 7)), db, 8'($urandom), 7'($urandom),
			8'($urandom));
	endtask

	task automatic event_item(input logic [7:0] code);
		event_byte(code, 8'($urandom));
	endtask

	// every byte a send can reach is loaded first
	task automatic send_request(input logic [6:0] addr, input logic [7:0] len);
		int i;
		for (i = 0; i < len; i++)
			if (!stocked[i])
				offer(KIND_LOAD, 8'($urandom), 8'($urandom), 8'(i), 7'($urandom),
					8'($urandom));
		offer(KIND_SEND, 8'($urandom), 8'($urandom), 8'($urandom), addr, len);
	endtask

	task automatic read_request(input logic [6:0] addr, input logic [7:0] len);
		offer(KIND_MREAD, 8'($urandom), 8'($urandom), 8'($urandom), addr, len);
	endtask

	task automatic set_reg(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow.configure(idx, value);
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (shadow.awaited_reactions.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// abandon whatever master work is left so a new packet gets through
	task automatic clear_master();
		if (shadow.out_busy) event_item(ST_MT_SLA_NACK);
		if (shadow.rd_busy) event_item(ST_MR_SLA_NACK);
		if (shadow.line_owned) event_item(ST_ARB_LOST);
	endtask

	task automatic master_read_body();
		int room, n, i;
		room = int'(shadow.rd_room);
		if ($urandom_range(0, 5) == 0) begin
			event_item(ST_MR_SLA_NACK);
			return;
		end
		event_item(ST_MR_SLA_ACK);
		if (room == 0)
			n = $urandom_range(1, 3);
		else
			n = room + (($urandom_range(0, 4) == 0) ? 1 : 0);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 11) == 0)
				event_item($urandom_range(0, 1) ? ST_MR_DATA_ACK : ST_MR_DATA_NACK);
			else
				event_item((i >= room - 1) ? ST_MR_DATA_NACK : ST_MR_DATA_ACK);
		end
		if (shadow.rd_busy && $urandom_range(0, 3) != 0) event_item(ST_MR_SLA_NACK);
	endtask

	task automatic master_write();
		int len, i;
		bit chained;
		clear_master();
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
		send_request(7'($urandom), 8'(len));
		// a read queued behind the send goes out on a repeated start
		chained = ($urandom_range(0, 4) == 0);
		if (chained)
			read_request(7'($urandom),
				8'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5)));
		event_item(($urandom_range(0, 3) == 0) ? ST_REP_START : ST_START);
		if ($urandom_range(0, 7) == 0) begin
			event_item(ST_MT_SLA_NACK);
		end else begin
			event_item(ST_MT_SLA_ACK);
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 23) == 0) begin
					event_item(ST_MT_DATA_NACK);
					break;
				end
				event_item(ST_MT_DATA_ACK);
			end
		end
		if (chained) begin
			event_item(ST_REP_START);
			master_read_body();
		end
	endtask

	task automatic master_read();
		clear_master();
		read_request(7'($urandom),
			8'(($urandom_range(0, 15) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6)));
		event_item(($urandom_range(0, 3) == 0) ? ST_REP_START : ST_START);
		master_read_body();
	endtask

	task automatic slave_write();
		int room, n, i;
		room = int'((shadow.slave_room > SLAVE_CAP_MAX) ? SLAVE_CAP_MAX : shadow.slave_room);
		case ($urandom_range(0, 7))
			0: begin
				event_item(ST_SR_ARB_GCALL);
				return;
			end
			1, 2: event_item(ST_SR_ARB_SLA_ACK);
			default: event_item(ST_SR_SLA_ACK);
		endcase
		if ($urandom_range(0, 15) == 0)
			n = room + $urandom_range(0, 2);
		else
			n = $urandom_range(0, (room < 6) ? room + 2 : 8);
		for (i = 0; i < n; i++) event_item(ST_SR_DATA_ACK);
		if ($urandom_range(0, 3) == 0) event_item(ST_SR_DATA_NACK);
		if ($urandom_range(0, 7) != 0) event_item(ST_SR_STOP);
	endtask

	task automatic stray_item();
		logic [1:0] k;
		k = 2'($urandom);
		if (k == KIND_SEND)
			send_request(7'($urandom),
				8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6)));
		else
			offer(k, 8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
	endtask

	task automatic random_phase(input int budget);
		int stop_at;
		stop_at = offered + budget;
		while (offered < stop_at) begin
			case ($urandom_range(0, 7))
				0, 1, 2: master_write();
				3, 4: master_read();
				5, 6: slave_write();
				default: repeat ($urandom_range(1, 4)) stray_item();
			endcase
		end
	endtask

	task automatic configure_slave(input bit on, input logic [7:0] room);
		logic [7:0] v;
		v = 8'($urandom);
		v[0] = on;
		set_reg(CFG_SLAVE_ENABLED, v);
		set_reg(CFG_SLAVE_CAPACITY, room);
	endtask

	task automatic directed_items();
		offer(KIND_LOAD, 8'($urandom), 8'hFF, 8'd0, 7'($urandom), 8'($urandom));
		offer(KIND_LOAD, 8'($urandom), 8'h00, 8'd1, 7'($urandom), 8'($urandom));
		send_request(7'h7F, 8'd2);
		send_request(7'h00, 8'd1);
		event_item(ST_START);
		event_item(ST_MT_SLA_ACK);
		event_item(ST_MT_DATA_ACK);
		event_item(ST_MT_DATA_ACK);
		// zero-capacity read: bytes only spoil it, the address nack hands it up
		read_request(7'h00, 8'd0);
		read_request(7'h7F, 8'd3);
		event_item(ST_REP_START);
		event_item(ST_MR_SLA_ACK);
		event_item(ST_MR_DATA_ACK);
		event_item(ST_MR_SLA_NACK);
		// capacity two: third byte overflows and the stop delivers nothing
		event_item(ST_SR_SLA_ACK);
		event_byte(ST_SR_DATA_ACK, 8'h00);
		event_byte(ST_SR_DATA_ACK, 8'hFF);
		event_item(ST_SR_DATA_ACK);
		event_item(ST_SR_STOP);
		event_item(ST_SR_ARB_SLA_ACK);
		event_item(ST_SR_DATA_NACK);
		event_item(ST_SR_STOP);
		event_item(ST_SR_ARB_GCALL);
		event_item(ST_UNLISTED);
		send_request(7'h2A, 8'd0);
		event_item(ST_START);
		event_item(ST_MT_SLA_ACK);
	endtask

	initial begin : sink
		int hold, taken;
		seq_reaction_t got;
		hold = 0;
		taken = 0;
		sink_steady = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= (hold == 0);
			if (hold > 0) hold--;
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.ctrl_write = ctrl_write;
				got.ctrl_bits = ctrl_bits;
				got.tx_valid = tx_valid;
				got.tx_byte = tx_byte;
				got.channel = channel;
				got.rx_valid = rx_valid;
				got.rx_byte = rx_byte;
				got.rx_index = rx_index;
				got.deliver_valid = deliver_valid;
				got.deliver_length = deliver_length;
				got.send_done = send_done;
				shadow.check_result(got);
				taken++;
				if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
				// long hold-off so the sender backs up into a full pipeline
				if (taken % 300 == 100)
					hold = 200;
				else
					hold = sink_steady ? 0 : $urandom_range(0, 19);
			end
		end
	end

	initial begin
		shadow = new();
		offered = 0;
		sender_steady = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = '0;
		status = '0;
		data_byte = '0;
		index = '0;
		address = '0;
		length = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure_slave(1, 8'd2);
		directed_items();

		quiesce();
		configure_slave(0, SLAVE_CAP_RESET);
		random_phase(135);
		quiesce();
		configure_slave(1, 8'd0);
		random_phase(135);
		quiesce();
		configure_slave(1, 8'd255);
		random_phase(135);
		quiesce();
		configure_slave(1, SLAVE_CAP_MAX);
		random_phase(135);
		quiesce();
		configure_slave(1, 8'd1);
		random_phase(135);
		quiesce();
		configure_slave(1, 8'($urandom_range(2, 12)));
		random_phase(135);
		quiesce();

		if (shadow.errors == 0)
			$display("twi_packet_sequencer: match");
		else
			$display("twi_packet_sequencer: mismatch");
		$finish;
	end

endmodule
